// ===== sv/rfc_pkg.sv =====
// rfc_pkg: shared types, constants and crc helpers for the record framer
// no dependencies
package rfc_pkg;

  localparam logic [31:0] RFC_CRC_POLY_REFL = 32'h82F63B78;
  localparam logic [31:0] RFC_ALL_ONES      = 32'hFFFFFFFF;
  localparam logic [31:0] RFC_MASK_DELTA    = 32'ha282ead8;
  localparam int          RFC_ROT_RIGHT     = 15;

  localparam int RFC_QUEUE_DEPTH = 4;

  localparam int RFC_PH_W = 5;
  localparam logic [RFC_PH_W-1:0] RFC_PH_HDR  = 5'd0;
  localparam logic [RFC_PH_W-1:0] RFC_PH_LEN4 = 5'd4;
  localparam logic [RFC_PH_W-1:0] RFC_PH_HCRC = 5'd8;
  localparam logic [RFC_PH_W-1:0] RFC_PH_DATA = 5'd12;
  localparam logic [RFC_PH_W-1:0] RFC_PH_FOOT = 5'd13;
  localparam logic [RFC_PH_W-1:0] RFC_PH_END  = 5'd16;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] record_length;
    logic [31:0] crc;
    logic        length_error;
  } rfc_cmd_t;

  typedef struct packed {
    logic     push;
    rfc_cmd_t cmd;
  } rfc_push_t;

  typedef struct packed {
    logic     empty;
    rfc_cmd_t head;
  } rfc_head_t;

  function automatic logic [31:0] rfc_crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] r;
    r = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ RFC_CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] rfc_mask(input logic [31:0] crc_in);
    logic [31:0] v;
    v = crc_in ^ RFC_ALL_ONES;
    v = {v[RFC_ROT_RIGHT-1:0], v[31:RFC_ROT_RIGHT]};
    return v + RFC_MASK_DELTA;
  endfunction

endpackage

// ===== sv/rfc_in_if.sv =====
// rfc_in_if: input byte channel of the record framer
// depends on nothing
interface rfc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] record_length;

  modport source (output valid, data_byte, first_byte, last_byte, record_length, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, record_length, output ready);
endinterface

// ===== sv/rfc_out_if.sv =====
// rfc_out_if: framed output byte channel of the record framer
// depends on nothing
interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       run_last;
  logic       record_end;
  logic       length_error;

  modport source (output valid, frame_byte, run_last, record_end, length_error, input ready);
  modport sink (input valid, frame_byte, run_last, record_end, length_error, output ready);
endinterface

// ===== sv/rfc_front.sv =====
// rfc_front: accepts payload beats, tracks record state and payload crc
// depends on rfc_pkg, rfc_in_if
module rfc_front import rfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rfc_in_if.sink    records,
  input  logic      queue_full,
  output rfc_push_t push
);

  logic [31:0] payload_crc;
  logic [31:0] byte_count;
  logic [31:0] expected_length;
  logic        in_record;

  logic        accept;
  logic [31:0] crc_next;
  logic [31:0] count_next;
  logic [31:0] expect_next;

  assign records.ready = !queue_full;
  assign accept = records.valid && records.ready;

  always_comb begin
    crc_next    = rfc_crc_byte(records.first_byte ? RFC_ALL_ONES : payload_crc,
                               records.data_byte);
    if (records.first_byte) begin
      count_next  = 32'd1;
      expect_next = records.record_length;
    end else begin
      count_next  = (byte_count == RFC_ALL_ONES) ? byte_count : byte_count + 32'd1;
      expect_next = expected_length;
    end
    push.push              = accept && (records.first_byte || in_record);
    push.cmd.data_byte     = records.data_byte;
    push.cmd.first_byte    = records.first_byte;
    push.cmd.last_byte     = records.last_byte;
    push.cmd.record_length = records.record_length;
    push.cmd.crc           = crc_next;
    push.cmd.length_error  = count_next != expect_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_crc     <= RFC_ALL_ONES;
      byte_count      <= '0;
      expected_length <= '0;
      in_record       <= 1'b0;
    end else if (push.push) begin
      expected_length <= expect_next;
      if (records.last_byte) begin
        payload_crc <= RFC_ALL_ONES;
        byte_count  <= '0;
        in_record   <= 1'b0;
      end else begin
        payload_crc <= crc_next;
        byte_count  <= count_next;
        in_record   <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/rfc_queue.sv =====
// rfc_queue: short command queue between front and back
// depends on rfc_pkg
module rfc_queue import rfc_pkg::*; #(
  parameter int DEPTH = RFC_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  rfc_push_t push,
  input  logic      pop,
  output logic      full,
  output rfc_head_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rfc_cmd_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_pop;

  assign full       = count == FULL_CNT;
  assign head.empty = count == '0;
  assign head.head  = slots[rd_ptr];
  assign do_pop     = pop && !head.empty;

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/rfc_back.sv =====
// rfc_back: expands queued commands into framed output beats
// depends on rfc_pkg, rfc_out_if
module rfc_back import rfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rfc_head_t head,
  output logic      pop,
  rfc_out_if.source frames
);

  logic [RFC_PH_W-1:0] phase;
  logic                started;
  logic [31:0]         hdr_crc;

  logic [RFC_PH_W-1:0] ph;
  logic [RFC_PH_W-1:0] ph_end;
  logic [RFC_PH_W-1:0] ph_hc;
  logic [RFC_PH_W-1:0] ph_ft;
  logic                load;
  logic                at_end;
  logic [7:0]          len_b;
  logic [7:0]          byte_sel;
  logic [31:0]         hdr_mask;
  logic [31:0]         pay_mask;
  logic [31:0]         hdr_crc_in;

  always_comb begin
    ph       = started ? phase : (head.head.first_byte ? RFC_PH_HDR : RFC_PH_DATA);
    ph_end   = head.head.last_byte ? RFC_PH_END : RFC_PH_DATA;
    at_end   = ph == ph_end;
    load     = !head.empty && (!frames.valid || frames.ready);
    ph_hc    = ph - RFC_PH_HCRC;
    ph_ft    = ph - RFC_PH_FOOT;
    len_b    = (ph < RFC_PH_LEN4) ? head.head.record_length[ph[1:0]*8 +: 8] : 8'd0;
    hdr_mask = rfc_mask(hdr_crc);
    pay_mask = rfc_mask(head.head.crc);
    hdr_crc_in = (ph == RFC_PH_HDR) ? RFC_ALL_ONES : hdr_crc;
    if (ph < RFC_PH_HCRC) begin
      byte_sel = len_b;
    end else if (ph < RFC_PH_DATA) begin
      byte_sel = hdr_mask[ph_hc[1:0]*8 +: 8];
    end else if (ph == RFC_PH_DATA) begin
      byte_sel = head.head.data_byte;
    end else begin
      byte_sel = pay_mask[ph_ft[1:0]*8 +: 8];
    end
    pop = load && at_end;
  end

  always_ff @(posedge clk) begin
    if (load && ph < RFC_PH_HCRC) begin
      hdr_crc <= rfc_crc_byte(hdr_crc_in, len_b);
    end
    if (load) begin
      frames.frame_byte   <= byte_sel;
      frames.run_last     <= at_end;
      frames.record_end   <= ph == RFC_PH_END;
      frames.length_error <= (ph == RFC_PH_END) && head.head.length_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames.valid <= 1'b0;
      started      <= 1'b0;
      phase        <= '0;
    end else begin
      if (load) begin
        frames.valid <= 1'b1;
        started      <= !at_end;
        phase        <= ph + 1'b1;
      end else if (frames.ready) begin
        frames.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/record_framer_masked_crc32c_top.sv =====
// record_framer_masked_crc32c_top: length-prefixed record framer with masked crc32c
// depends on rfc_pkg, rfc_in_if, rfc_out_if, rfc_front, rfc_queue, rfc_back
//
//  channel   dir  payload                                          beats per item
//  records   in   data_byte, first_byte, last_byte, record_length  1
//  frames    out  frame_byte, run_last, record_end, length_error   1 to 17
//
// one input beat per cycle enters the front while the queue is not full; the back emits one
// output beat per cycle while a command is queued and frames is ready; a first byte expands
// to 13 beats, a last byte adds 4 footer beats, so the output port sets the sustained rate
// synchronous active-high reset empties the queue and closes any open record
// the queue lets the front keep taking beats while the output stalls, until it fills
module record_framer_masked_crc32c_top import rfc_pkg::*; #(
  parameter int QUEUE_DEPTH = RFC_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  rfc_in_if.sink    records,
  rfc_out_if.source frames
);

  rfc_push_t push;
  rfc_head_t head;
  logic      queue_full;
  logic      pop;

  rfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .records    (records),
    .queue_full (queue_full),
    .push       (push)
  );

  rfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  rfc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .frames (frames)
  );

endmodule
